### design/bdq_pkg.sv
package bdq_pkg;

    localparam int KIND_W      = 3;
    localparam int STATUS_W    = 2;
    localparam int ID_OUT_W    = 3;
    localparam int COUNT_W     = 32;
    localparam int REF_W       = 48;
    localparam int CFG_W       = 4;
    localparam int CFG_RESET   = 8;
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 88;
    localparam int OUT_USED_W  = ID_OUT_W + COUNT_W + REF_W + 1;

    typedef enum logic [KIND_W-1:0] {
        KIND_ENQ    = 3'd0,
        KIND_DEQ    = 3'd1,
        KIND_REMOVE = 3'd2,
        KIND_HEAD   = 3'd3,
        KIND_READ   = 3'd4
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_EMPTY      = 2'd2,
        ST_NOT_QUEUED = 2'd3
    } t_status;

endpackage

### design/bdq_data_ram.sv
module bdq_data_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 80
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/buffer_descriptor_queue.sv
// buffer descriptor queue: a pool of SLOTS slots holding a byte count and a buffer
// reference, kept as a lifo free list and a doubly linked fifo of queued slots.
// input channel (i_s_*): one command per transaction, kind in tuser, slot id,
// byte count and buffer reference in tdata. output channel (o_m_*): exactly one
// result per command, status in tuser, slot id, count, reference and the
// can-enqueue flag in tdata.
// each command goes through these steps from acceptance to a result in the output register:
// the link and data memories are read at acceptance (synchronous, registered reads),
// the next step unlinks or appends, the one after releases an unlinked slot or links
// the appended one behind the old newest, and loads the result. a new command is
// accepted in the cycle after the result is loaded, so none is taken before the last is done.
// a result waits in the output register while the receiver stalls; the next
// command is accepted meanwhile and holds in its last step until the register frees.
// reset (i_rst_n low, synchronous) and any write of buffers_in_use rebuild the pool
// at once: queue empty, slots 0 to buffers_in_use-1 free with the highest on top.
// free-chain links come from per-slot valid bits, so no clearing pass is needed.
module buffer_descriptor_queue #(
    parameter int SLOTS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [bdq_pkg::CFG_W-1:0]          i_cfg_wdata,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // kind
    input  logic [bdq_pkg::KIND_W-1:0]         i_s_tuser,
    // slot_id, byte_count, buffer_ref, zero pad
    input  logic [bdq_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // status
    output logic [bdq_pkg::STATUS_W-1:0]       o_m_tuser,
    // result_id, result_count, result_ref, can_enqueue, zero pad
    output logic [bdq_pkg::OUT_TDATA_W-1:0]    o_m_tdata
);

    localparam int ID_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PTR_W  = $clog2(SLOTS + 1);
    localparam int XW     = (PTR_W > bdq_pkg::ID_OUT_W) ? PTR_W : bdq_pkg::ID_OUT_W;
    localparam int CW     = (PTR_W > bdq_pkg::CFG_W) ? PTR_W : bdq_pkg::CFG_W;
    localparam int DW     = bdq_pkg::COUNT_W + bdq_pkg::REF_W;
    localparam int PAD_W  = bdq_pkg::OUT_TDATA_W - bdq_pkg::OUT_USED_W;
    localparam logic [PTR_W-1:0] NIL = PTR_W'(SLOTS);
    localparam logic [PTR_W-1:0] RESET_N =
        PTR_W'((bdq_pkg::CFG_RESET > SLOTS) ? SLOTS : bdq_pkg::CFG_RESET);
    localparam logic [PTR_W-1:0] RESET_TOP = (RESET_N != '0) ? RESET_N - 1'b1 : NIL;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FIN
    } t_state;

    function automatic logic ptr_ok(input logic [PTR_W-1:0] p);
        return p < NIL;
    endfunction

    // control registers
    t_state                       r_state, n_state;
    logic [PTR_W-1:0]             r_n;
    logic [PTR_W-1:0]             r_free_top, n_free_top;
    logic [PTR_W-1:0]             r_oldest, n_oldest;
    logic [PTR_W-1:0]             r_newest, n_newest;
    logic [SLOTS-1:0]             r_queued;
    logic [SLOTS-1:0]             r_old_valid;
    logic                         r_out_valid, n_out_valid;

    // command and read-back registers
    bdq_pkg::t_kind               r_kind;
    bdq_pkg::t_status             r_fail;
    logic                         r_ok;
    logic [ID_W-1:0]              r_slot;
    logic [bdq_pkg::COUNT_W-1:0]  r_cnt_in;
    logic [bdq_pkg::REF_W-1:0]    r_ref_in;
    logic [PTR_W-1:0]             r_prev_newest;
    logic [PTR_W-1:0]             r_older_rd;
    logic [PTR_W-1:0]             r_newer_rd;
    logic [bdq_pkg::OUT_TDATA_W-1:0] r_out_tdata, n_out_tdata;
    logic [bdq_pkg::STATUS_W-1:0] r_out_tuser, n_out_tuser;

    // link memories
    logic [PTR_W-1:0]             r_older_mem [SLOTS];
    logic [PTR_W-1:0]             r_newer_mem [SLOTS];

    logic                         in_fire;
    logic                         out_go;
    bdq_pkg::t_kind               in_kind;
    logic [XW-1:0]                id_x;
    logic [ID_W-1:0]              id_idx;
    logic                         id_ok;
    logic                         a_ok;
    logic [ID_W-1:0]              a_tgt;
    bdq_pkg::t_status             a_fail;
    logic [ID_W-1:0]              rd_idx;
    logic [PTR_W-1:0]             rd_ptr;
    logic [PTR_W-1:0]             older_fallback;
    logic [PTR_W-1:0]             slot_ptr;
    logic [PTR_W-1:0]             cfg_n;
    logic [PTR_W-1:0]             cfg_top;
    logic                         q_set, q_clr;
    logic                         older_we, newer_we, data_we;
    logic [ID_W-1:0]              older_waddr, newer_waddr;
    logic [PTR_W-1:0]             older_wdata, newer_wdata;
    logic                         out_load;
    logic                         released;
    logic [DW-1:0]                data_rd;
    logic [bdq_pkg::COUNT_W-1:0]  res_cnt;
    logic [bdq_pkg::REF_W-1:0]    res_ref;
    logic                         res_can;

    assign o_s_tready = (r_state == S_IDLE);
    assign in_fire    = i_s_tvalid && o_s_tready;
    assign out_go     = !r_out_valid || i_m_tready;
    assign in_kind    = bdq_pkg::t_kind'(i_s_tuser);
    assign slot_ptr   = PTR_W'(r_slot);

    // saturate the pool size to the number of slots
    assign cfg_n   = (CW'(i_cfg_wdata) > CW'(SLOTS)) ? NIL : PTR_W'(i_cfg_wdata);
    assign cfg_top = (cfg_n != '0) ? cfg_n - 1'b1 : NIL;

    // slot id lookup, clamped so the index stays in the array
    assign id_x   = XW'(i_s_tdata[bdq_pkg::ID_OUT_W-1:0]);
    assign id_idx = (id_x < XW'(SLOTS)) ? id_x[ID_W-1:0] : '0;
    assign id_ok  = (id_x < XW'(SLOTS)) && r_queued[id_idx];

    always_comb begin
        a_ok   = 1'b0;
        a_tgt  = '0;
        a_fail = bdq_pkg::ST_OK;
        case (in_kind)
            bdq_pkg::KIND_ENQ: begin
                a_ok   = ptr_ok(r_free_top);
                a_tgt  = r_free_top[ID_W-1:0];
                a_fail = bdq_pkg::ST_FULL;
            end
            bdq_pkg::KIND_DEQ, bdq_pkg::KIND_HEAD: begin
                a_ok   = ptr_ok(r_oldest);
                a_tgt  = r_oldest[ID_W-1:0];
                a_fail = bdq_pkg::ST_EMPTY;
            end
            bdq_pkg::KIND_REMOVE, bdq_pkg::KIND_READ: begin
                a_ok   = id_ok;
                a_tgt  = id_idx;
                a_fail = bdq_pkg::ST_NOT_QUEUED;
            end
            default: begin
                a_ok   = 1'b0;
            end
        endcase
    end

    assign rd_idx = a_ok ? a_tgt : '0;
    assign rd_ptr = PTR_W'(rd_idx);
    // never-written older links read as the descending free chain
    assign older_fallback = (rd_ptr != '0 && rd_ptr < r_n) ? rd_ptr - 1'b1 : NIL;

    always_comb begin
        n_state     = r_state;
        n_free_top  = r_free_top;
        n_oldest    = r_oldest;
        n_newest    = r_newest;
        n_out_valid = r_out_valid && !i_m_tready;
        q_set       = 1'b0;
        q_clr       = 1'b0;
        older_we    = 1'b0;
        older_waddr = r_slot;
        older_wdata = NIL;
        newer_we    = 1'b0;
        newer_waddr = r_slot;
        newer_wdata = NIL;
        data_we     = 1'b0;
        out_load    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_FIN;
                if (r_ok) begin
                    case (r_kind)
                        bdq_pkg::KIND_ENQ: begin
                            data_we     = 1'b1;
                            older_we    = 1'b1;
                            older_wdata = r_newest;
                            newer_we    = 1'b1;
                            newer_wdata = NIL;
                            n_free_top  = r_older_rd;
                            q_set       = 1'b1;
                            if (!ptr_ok(r_newest)) begin
                                n_oldest = slot_ptr;
                            end
                            n_newest    = slot_ptr;
                        end
                        bdq_pkg::KIND_DEQ, bdq_pkg::KIND_REMOVE: begin
                            q_clr = 1'b1;
                            if (ptr_ok(r_newer_rd)) begin
                                older_we    = 1'b1;
                                older_waddr = r_newer_rd[ID_W-1:0];
                                older_wdata = r_older_rd;
                            end else begin
                                n_newest = r_older_rd;
                            end
                            if (ptr_ok(r_older_rd)) begin
                                newer_we    = 1'b1;
                                newer_waddr = r_older_rd[ID_W-1:0];
                                newer_wdata = r_newer_rd;
                            end else begin
                                n_oldest = r_newer_rd;
                            end
                        end
                        default: begin
                            q_clr = 1'b0;
                        end
                    endcase
                end
            end
            S_FIN: begin
                if (out_go) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (r_ok) begin
                        case (r_kind)
                            bdq_pkg::KIND_ENQ: begin
                                if (ptr_ok(r_prev_newest)) begin
                                    newer_we    = 1'b1;
                                    newer_waddr = r_prev_newest[ID_W-1:0];
                                    newer_wdata = slot_ptr;
                                end
                            end
                            bdq_pkg::KIND_DEQ, bdq_pkg::KIND_REMOVE: begin
                                older_we    = 1'b1;
                                older_waddr = r_slot;
                                older_wdata = r_free_top;
                                n_free_top  = slot_ptr;
                            end
                            default: begin
                                older_we = 1'b0;
                            end
                        endcase
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // result assembly in the last step
    assign released = r_ok && (r_kind == bdq_pkg::KIND_DEQ || r_kind == bdq_pkg::KIND_REMOVE);
    assign res_can  = released || ptr_ok(r_free_top);
    assign res_cnt  = !r_ok ? '0 :
                      (r_kind == bdq_pkg::KIND_ENQ) ? r_cnt_in : data_rd[bdq_pkg::COUNT_W-1:0];
    assign res_ref  = !r_ok ? '0 :
                      (r_kind == bdq_pkg::KIND_ENQ) ? r_ref_in : data_rd[DW-1:bdq_pkg::COUNT_W];

    always_comb begin
        n_out_tuser = r_ok ? bdq_pkg::ST_OK : r_fail;
        n_out_tdata = {{PAD_W{1'b0}}, res_can, res_ref, res_cnt,
                       (r_ok ? bdq_pkg::ID_OUT_W'(r_slot) : {bdq_pkg::ID_OUT_W{1'b0}})};
    end

    bdq_data_ram #(
        .DEPTH (SLOTS),
        .WIDTH (DW)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (r_slot),
        .i_wdata ({r_ref_in, r_cnt_in}),
        .i_re    (in_fire),
        .i_raddr (rd_idx),
        .o_rdata (data_rd)
    );

    // link memories, read at command acceptance
    always_ff @(posedge i_clk) begin
        if (older_we) begin
            r_older_mem[older_waddr] <= older_wdata;
        end
        if (newer_we) begin
            r_newer_mem[newer_waddr] <= newer_wdata;
        end
        if (in_fire) begin
            r_older_rd <= r_old_valid[rd_idx] ? r_older_mem[rd_idx] : older_fallback;
            r_newer_rd <= r_newer_mem[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_n         <= RESET_N;
            r_free_top  <= RESET_TOP;
            r_oldest    <= NIL;
            r_newest    <= NIL;
            r_queued    <= '0;
            r_old_valid <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_free_top  <= n_free_top;
            r_oldest    <= n_oldest;
            r_newest    <= n_newest;
            if (q_set) begin
                r_queued[r_slot] <= 1'b1;
            end
            if (q_clr) begin
                r_queued[r_slot] <= 1'b0;
            end
            if (older_we) begin
                r_old_valid[older_waddr] <= 1'b1;
            end
            // pool rebuild overrides any pool update
            if (i_cfg_we) begin
                r_n         <= cfg_n;
                r_free_top  <= cfg_top;
                r_oldest    <= NIL;
                r_newest    <= NIL;
                r_queued    <= '0;
                r_old_valid <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_kind   <= in_kind;
            r_fail   <= a_fail;
            r_ok     <= a_ok;
            r_slot   <= a_tgt;
            r_cnt_in <= i_s_tdata[bdq_pkg::ID_OUT_W +: bdq_pkg::COUNT_W];
            r_ref_in <= i_s_tdata[bdq_pkg::ID_OUT_W + bdq_pkg::COUNT_W +: bdq_pkg::REF_W];
        end
        if (r_state == S_EXEC) begin
            r_prev_newest <= r_newest;
        end
        if (out_load) begin
            r_out_tdata <= n_out_tdata;
            r_out_tuser <= n_out_tuser;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_tdata;
    assign o_m_tuser  = r_out_tuser;

endmodule

### design/bdq_checker.sv
module bdq_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [bdq_pkg::STATUS_W-1:0]    o_m_tuser,
    input logic [bdq_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int CAN_BIT = bdq_pkg::OUT_USED_W - 1;

    // one command in flight: no acceptance right after one
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("command accepted while another is in flight");

    // failed results carry no slot, count or reference
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != bdq_pkg::ST_OK |-> o_m_tdata[CAN_BIT-1:0] == '0)
        else $error("failed result carries nonzero payload");

    // a full report means no free slot remains
    a_full_no_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == bdq_pkg::ST_FULL |-> !o_m_tdata[CAN_BIT])
        else $error("full status with can_enqueue set");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result changed");

endmodule

bind buffer_descriptor_queue bdq_checker u_bdq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tuser  (o_m_tuser),
    .o_m_tdata  (o_m_tdata)
);
